// ===== hdl/lsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, limits and register indexes for the laser segment interpolator.
// No dependencies; imported by laser_segment_interpolator_core.
package lsi_pkg;

    // Largest number of points emitted for one segment
    localparam int MAX_STEPS = 64;

    // Coordinate width and derived widths
    localparam int CW   = 16;
    localparam int NB   = $clog2(MAX_STEPS + 1);   // step count / step index
    localparam int D2W  = 2 * CW + 1;              // dx^2 + dy^2
    localparam int SQW  = 2 * NB + 2 * CW + 1;     // (n*s)^2 and its odd increments
    localparam int DCW  = $clog2(CW);              // divider bit counter

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_SEGMENT_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WINDOW_LOW     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_WINDOW_HIGH    = 2'd2;
    localparam logic [CFG_IW-1:0] REG_BLANK_CHECK    = 2'd3;

    // Register reset values
    localparam logic [CW-1:0] SEGMENT_LENGTH_RST = 16'd1638;
    localparam logic [CW-1:0] WINDOW_LOW_RST     = 16'd0;
    localparam logic [CW-1:0] WINDOW_HIGH_RST    = 16'hFFFF;

    typedef logic [CW-1:0] coord_t;

endpackage

// ===== hdl/laser_segment_interpolator_core.sv =====
`timescale 1ns / 1ps
// Laser segment interpolator: stores path points and emits interpolated points.
// Depends on lsi_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, fields in_x, in_y, path_start): one
//   path point per item. in_stall is high whenever a segment is in progress.
//   A point with path_start set, or any point while none is stored, is only
//   stored and the block is ready again in the next cycle.
//   Output channel (out_valid / out_stall, fields out_x, out_y, blanked,
//   last_of_run): n points per segment, from the stored point toward the new
//   one; last_of_run marks the final point of the segment.
//   Steps per segment: accept, then the shared 16x16 multiplier squares
//   dx, dy and segment_length in turn, a setup step, a step-count search
//   by repeated addition and comparison, the shared restoring divider
//   (dx/n then dy/n), then the n points are emitted in order whenever the
//   output register is free or out_stall is low; n is at most MAX_STEPS.
//   The result stage is a register: the last point may wait in it while the
//   next item is accepted. out_stall holds the emitting sequence in place.
//   The user writes configuration (cfg_we, cfg_index, cfg_data) only while
//   idle; the block itself does not enforce this. Reset clears the stored
//   point and the output valid flag and loads register defaults.
module laser_segment_interpolator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lsi_pkg::coord_t             in_x,
    input  lsi_pkg::coord_t             in_y,
    input  logic                        path_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lsi_pkg::coord_t             out_x,
    output lsi_pkg::coord_t             out_y,
    output logic                        blanked,
    output logic                        last_of_run,
    input  logic                        cfg_we,
    input  logic [lsi_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [lsi_pkg::CFG_DW-1:0]  cfg_data
);
    import lsi_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQS  = 4'd3;
    localparam logic [3:0] S_INIT = 4'd4;
    localparam logic [3:0] S_SRCH = 4'd5;
    localparam logic [3:0] S_DIVX = 4'd6;
    localparam logic [3:0] S_DIVY = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    // Configuration registers
    coord_t seg_len_reg;
    coord_t win_lo_reg;
    coord_t win_hi_reg;
    logic   blank_en_reg;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic          have_prev_reg, have_prev_next;
    logic          out_valid_reg, out_valid_next;

    // Working registers
    coord_t            prev_x_reg, prev_x_next;
    coord_t            prev_y_reg, prev_y_next;
    coord_t            new_x_reg, new_x_next;
    coord_t            new_y_reg, new_y_next;
    logic [CW:0]       dx_reg, dx_next;
    logic [CW:0]       dy_reg, dy_next;
    logic [D2W-1:0]    d2_reg, d2_next;
    logic [2*CW-1:0]   s2_reg, s2_next;
    logic [SQW-1:0]    sq_reg, sq_next;
    logic [SQW-1:0]    odd_reg, odd_next;
    logic [NB-1:0]     n_reg, n_next;
    logic [CW-1:0]     div_sh_reg, div_sh_next;
    logic [NB-1:0]     div_rem_reg, div_rem_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [CW:0]       qdx_reg, qdx_next;
    logic [CW:0]       qdy_reg, qdy_next;
    logic [NB-1:0]     rdx_reg, rdx_next;
    logic [NB-1:0]     rdy_reg, rdy_next;
    logic [NB-1:0]     j_reg, j_next;
    logic [CW:0]       accx_reg, accx_next;
    logic [CW:0]       accy_reg, accy_next;
    logic [NB-1:0]     remx_reg, remx_next;
    logic [NB-1:0]     remy_reg, remy_next;
    coord_t            out_x_reg, out_x_next;
    coord_t            out_y_reg, out_y_next;
    logic              blanked_reg, blanked_next;
    logic              last_reg, last_next;

    // Shared multiplier
    logic [CW-1:0]     mul_a;
    logic [2*CW-1:0]   mul_p;
    logic [CW-1:0]     mag_dx;
    logic [CW-1:0]     mag_dy;

    // Shared divider step
    logic [NB:0]       div_rem_sh;
    logic              div_ge;
    logic [NB:0]       div_rem_new;
    logic [CW-1:0]     div_q_new;
    logic              div_neg;
    logic [CW:0]       div_qd;
    logic [NB-1:0]     div_rd;

    // Emit path
    logic [NB:0]       rsum_x;
    logic [NB:0]       rsum_y;
    logic              wrap_x;
    logic              wrap_y;
    coord_t            px;
    coord_t            py;
    logic              pt_last;
    logic              in_win;
    logic              out_free;
    logic              in_take;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign blanked     = blanked_reg;
    assign last_of_run = last_reg;

    // Magnitudes of the deltas
    assign mag_dx = dx_reg[CW] ? CW'(-dx_reg) : dx_reg[CW-1:0];
    assign mag_dy = dy_reg[CW] ? CW'(-dy_reg) : dy_reg[CW-1:0];

    // Square the operand picked by the sequencer
    always_comb
    begin
        case (state_reg)
            S_SQX:   mul_a = mag_dx;
            S_SQY:   mul_a = mag_dy;
            default: mul_a = seg_len_reg;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    // One restoring divider step and the floor correction for a negative delta
    assign div_rem_sh  = {div_rem_reg, div_sh_reg[CW-1]};
    assign div_ge      = (div_rem_sh >= {1'b0, n_reg});
    assign div_rem_new = div_ge ? (div_rem_sh - {1'b0, n_reg}) : div_rem_sh;
    assign div_q_new   = {div_sh_reg[CW-2:0], div_ge};
    assign div_neg     = (state_reg == S_DIVY) ? dy_reg[CW] : dx_reg[CW];

    always_comb
    begin
        if (!div_neg)
        begin
            div_qd = {1'b0, div_q_new};
            div_rd = div_rem_new[NB-1:0];
        end
        else if (div_rem_new[NB-1:0] != '0)
        begin
            div_qd = ~{1'b0, div_q_new};
            div_rd = n_reg - div_rem_new[NB-1:0];
        end
        else
        begin
            div_qd = (~{1'b0, div_q_new}) + 1'b1;
            div_rd = '0;
        end
    end

    // Current point and its remainder carries
    assign px      = prev_x_reg + accx_reg[CW-1:0];
    assign py      = prev_y_reg + accy_reg[CW-1:0];
    assign pt_last = (j_reg == (n_reg - 1'b1));
    assign in_win  = (px >= win_lo_reg) && (px <= win_hi_reg) &&
                     (py >= win_lo_reg) && (py <= win_hi_reg);
    assign rsum_x  = {1'b0, remx_reg} + {1'b0, rdx_reg};
    assign rsum_y  = {1'b0, remy_reg} + {1'b0, rdy_reg};
    assign wrap_x  = (rsum_x >= {1'b0, n_reg});
    assign wrap_y  = (rsum_y >= {1'b0, n_reg});

    // Sequencer next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        new_x_next     = new_x_reg;
        new_y_next     = new_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        d2_next        = d2_reg;
        s2_next        = s2_reg;
        sq_next        = sq_reg;
        odd_next       = odd_reg;
        n_next         = n_reg;
        div_sh_next    = div_sh_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        qdx_next       = qdx_reg;
        qdy_next       = qdy_reg;
        rdx_next       = rdx_reg;
        rdy_next       = rdy_reg;
        j_next         = j_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        blanked_next   = blanked_reg;
        last_next      = last_reg;

        // Drop the output item once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (path_start || !have_prev_reg)
                    begin
                        prev_x_next    = in_x;
                        prev_y_next    = in_y;
                        have_prev_next = 1'b1;
                    end
                    else
                    begin
                        new_x_next = in_x;
                        new_y_next = in_y;
                        dx_next    = {1'b0, in_x} - {1'b0, prev_x_reg};
                        dy_next    = {1'b0, in_y} - {1'b0, prev_y_reg};
                        state_next = S_SQX;
                    end
                end
            end

            S_SQX:
            begin
                d2_next    = {1'b0, mul_p};
                state_next = S_SQY;
            end

            S_SQY:
            begin
                d2_next    = d2_reg + {1'b0, mul_p};
                state_next = S_SQS;
            end

            S_SQS:
            begin
                s2_next    = mul_p;
                state_next = S_INIT;
            end

            // Start the search at n = 1: (n*s)^2 = s^2, next increment 3*s^2
            S_INIT:
            begin
                n_next     = NB'(1);
                sq_next    = {{(SQW-2*CW){1'b0}}, s2_reg};
                odd_next   = {{(SQW-2*CW){1'b0}}, s2_reg}
                           + {{(SQW-2*CW-1){1'b0}}, s2_reg, 1'b0};
                state_next = S_SRCH;
            end

            // Advance n until (n*s)^2 reaches dx^2 + dy^2, saturating at the limit
            S_SRCH:
            begin
                if (sq_reg >= {{(SQW-D2W){1'b0}}, d2_reg} ||
                    n_reg == NB'(MAX_STEPS - 1))
                begin
                    if (sq_reg < {{(SQW-D2W){1'b0}}, d2_reg})
                    begin
                        n_next = NB'(MAX_STEPS);
                    end
                    div_sh_next  = mag_dx;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIVX;
                end
                else
                begin
                    n_next   = n_reg + 1'b1;
                    sq_next  = sq_reg + odd_reg;
                    odd_next = odd_reg + {{(SQW-2*CW-1){1'b0}}, s2_reg, 1'b0};
                end
            end

            // Floor-divide dx by n, one quotient bit a cycle
            S_DIVX:
            begin
                div_sh_next  = div_q_new;
                div_rem_next = div_rem_new[NB-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(CW - 1))
                begin
                    qdx_next     = div_qd;
                    rdx_next     = div_rd;
                    div_sh_next  = mag_dy;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIVY;
                end
            end

            // Floor-divide dy by n
            S_DIVY:
            begin
                div_sh_next  = div_q_new;
                div_rem_next = div_rem_new[NB-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(CW - 1))
                begin
                    qdy_next   = div_qd;
                    rdy_next   = div_rd;
                    j_next     = '0;
                    accx_next  = '0;
                    accy_next  = '0;
                    remx_next  = '0;
                    remy_next  = '0;
                    state_next = S_EMIT;
                end
            end

            // Emit one point per free output slot, then store the new point
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = px;
                    out_y_next     = py;
                    blanked_next   = blank_en_reg && !in_win;
                    last_next      = pt_last;
                    j_next         = j_reg + 1'b1;
                    accx_next      = accx_reg + qdx_reg + {{CW{1'b0}}, wrap_x};
                    accy_next      = accy_reg + qdy_reg + {{CW{1'b0}}, wrap_y};
                    remx_next      = wrap_x ? NB'(rsum_x - {1'b0, n_reg}) : rsum_x[NB-1:0];
                    remy_next      = wrap_y ? NB'(rsum_y - {1'b0, n_reg}) : rsum_y[NB-1:0];
                    if (pt_last)
                    begin
                        prev_x_next = new_x_reg;
                        prev_y_next = new_y_reg;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg  <= SEGMENT_LENGTH_RST;
            win_lo_reg   <= WINDOW_LOW_RST;
            win_hi_reg   <= WINDOW_HIGH_RST;
            blank_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEGMENT_LENGTH: seg_len_reg  <= cfg_data;
                REG_WINDOW_LOW:     win_lo_reg   <= cfg_data;
                REG_WINDOW_HIGH:    win_hi_reg   <= cfg_data;
                REG_BLANK_CHECK:    blank_en_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        new_x_reg   <= new_x_next;
        new_y_reg   <= new_y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        d2_reg      <= d2_next;
        s2_reg      <= s2_next;
        sq_reg      <= sq_next;
        odd_reg     <= odd_next;
        n_reg       <= n_next;
        div_sh_reg  <= div_sh_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        qdx_reg     <= qdx_next;
        qdy_reg     <= qdy_next;
        rdx_reg     <= rdx_next;
        rdy_reg     <= rdy_next;
        j_reg       <= j_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        remx_reg    <= remx_next;
        remy_reg    <= remy_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        blanked_reg <= blanked_next;
        last_reg    <= last_next;
    end

endmodule
